[rtl/tes_pkg.sv]
// Package with the command and result codes and shared types of the timed event scheduler.
`default_nettype none
package tes_pkg;

    localparam int unsigned POOL_DEPTH_DEF = 16;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned TIME_W = 32;

    typedef enum logic [3:0] {
        CMD_REGISTER   = 4'd0,
        CMD_REREGISTER = 4'd1,
        CMD_CLEAR      = 4'd2,
        CMD_SET        = 4'd3,
        CMD_SET_RELOAD = 4'd4,
        CMD_SET_DELTA  = 4'd5,
        CMD_SET_NOW    = 4'd6,
        CMD_DELETE     = 4'd7,
        CMD_READ       = 4'd8,
        CMD_CHECK      = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ALLOC     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_ACK       = 3'd2,
        KIND_ARMED     = 3'd3,
        KIND_NOT_ARMED = 3'd4,
        KIND_FIRED     = 3'd5,
        KIND_SCAN_END  = 3'd6
    } kind_t;

    // One decoded request as it travels from the front part to the back part.
    typedef struct packed {
        logic [3:0]        mode;
        logic [IDX_W-1:0]  slot;
        logic              slot_ok;
        logic [TIME_W-1:0] time_value;
        logic [TIME_W-1:0] reload_value;
        logic [TIME_W-1:0] event_param;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END
    } state_t;

endpackage
`default_nettype wire

[rtl/tes_front.sv]
// Front part: accepts requests, checks the slot range and writes them into a short queue.
`default_nettype none
module tes_front
    import tes_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [3:0]    in_mode,
    input  wire logic [3:0]    in_slot,
    input  wire logic [31:0]   in_time,
    input  wire logic [31:0]   in_reload,
    input  wire logic [31:0]   in_param,
    input  wire logic [31:0]   in_now,
    output logic               q_valid,
    input  wire logic          q_ready,
    output req_t               q_req
);
    req_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    req_t       req;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        req.mode         = in_mode;
        req.slot         = in_slot;
        req.slot_ok      = ({1'b0, in_slot} < 5'(POOL_DEPTH));
        req.time_value   = in_time;
        req.reload_value = in_reload;
        req.event_param  = in_param;
        req.now_time     = in_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= req;
    end
endmodule
`default_nettype wire

[rtl/tes_back.sv]
// Back part: holds the event slots, carries out commands and scans the pool on a check.
`default_nettype none
module tes_back
    import tes_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire req_t        q_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_kind,
    output logic [3:0]       out_index,
    output logic [31:0]      out_time,
    output logic [31:0]      out_param,
    output logic             out_last
);
    logic [POOL_DEPTH-1:0] reg_mark_reg, armed_reg;
    logic [31:0] due_reg    [POOL_DEPTH];
    logic [31:0] reload_reg [POOL_DEPTH];
    logic [31:0] param_reg  [POOL_DEPTH];
    logic [31:0] cur_time_reg;

    state_t state_reg, state_next;
    logic [4:0] scan_reg, scan_next;
    logic [31:0] now_reg;

    logic        ov_reg;
    logic [2:0]  ok_reg;
    logic [3:0]  oi_reg;
    logic [31:0] ot_reg, op_reg;
    logic        ol_reg;

    logic out_free;
    logic take;
    logic load_out;
    logic read_hit;
    logic [3:0] s;
    logic [IDX_W-1:0] si;
    logic found;
    logic [3:0] free_idx;
    logic [IDX_W-1:0] sc;
    logic fire;
    logic [31:0] diff;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_kind  = ok_reg;
    assign out_index = oi_reg;
    assign out_time  = ot_reg;
    assign out_param = op_reg;
    assign out_last  = ol_reg;

    assign s  = q_req.slot;
    assign si = q_req.slot_ok ? s : '0;
    assign sc = scan_reg[IDX_W-1:0];
    assign diff = now_reg - due_reg[sc];
    assign fire = armed_reg[sc] && !diff[31];
    assign read_hit = q_req.slot_ok && armed_reg[si];

    // A new result enters the output register on a non-check command, a fired slot or scan end.
    assign load_out = (take && q_req.mode != CMD_CHECK) ||
                      (state_reg == ST_SCAN && fire && out_free) ||
                      (state_reg == ST_END && out_free);

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!reg_mark_reg[i]) begin
                found    = 1'b1;
                free_idx = 4'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        take       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                take = q_valid && out_free;
                if (take && q_req.mode == CMD_CHECK) begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                end
            end
            ST_SCAN: begin
                if (out_free || !fire) begin
                    scan_next = scan_reg + 5'd1;
                    if (scan_reg == 5'(POOL_DEPTH - 1)) state_next = ST_END;
                end
            end
            ST_END: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
    assign q_ready = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            ov_reg    <= load_out || (ov_reg && !out_ready);
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            if (q_req.mode == CMD_REGISTER) begin
                ok_reg <= found ? KIND_ALLOC : KIND_FULL;
                oi_reg <= found ? free_idx : 4'd0;
                ot_reg <= '0;
            end else if (q_req.mode == CMD_READ) begin
                ok_reg <= read_hit ? KIND_ARMED : KIND_NOT_ARMED;
                oi_reg <= s;
                ot_reg <= read_hit ? due_reg[si] : 32'd0;
            end else begin
                ok_reg <= KIND_ACK;
                oi_reg <= '0;
                ot_reg <= '0;
            end
            op_reg <= '0;
            ol_reg <= 1'b1;
        end else if (state_reg == ST_SCAN && fire && out_free) begin
            ok_reg <= KIND_FIRED;
            oi_reg <= 4'(sc);
            ot_reg <= due_reg[sc];
            op_reg <= param_reg[sc];
            ol_reg <= 1'b0;
        end else if (state_reg == ST_END && out_free) begin
            ok_reg <= KIND_SCAN_END;
            oi_reg <= '0;
            ot_reg <= '0;
            op_reg <= '0;
            ol_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && q_req.mode == CMD_CHECK) now_reg <= q_req.now_time;
    end

    // Slot state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_mark_reg <= '0;
            armed_reg    <= '0;
            cur_time_reg <= '0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                due_reg[i]    <= '0;
                reload_reg[i] <= '0;
                param_reg[i]  <= '0;
            end
        end else if (take) begin
            case (q_req.mode)
                CMD_REGISTER: if (found) reg_mark_reg[free_idx[IDX_W-1:0]] <= 1'b1;
                CMD_REREGISTER: if (q_req.slot_ok) begin
                    reg_mark_reg[si] <= 1'b1;
                    armed_reg[si]    <= 1'b0;
                end
                CMD_CLEAR: if (q_req.slot_ok) begin
                    armed_reg[si]  <= 1'b0;
                    due_reg[si]    <= '0;
                    reload_reg[si] <= '0;
                end
                CMD_SET: if (q_req.slot_ok) begin
                    armed_reg[si] <= 1'b1;
                    due_reg[si]   <= q_req.time_value;
                    param_reg[si] <= q_req.event_param;
                end
                CMD_SET_RELOAD: if (q_req.slot_ok) begin
                    armed_reg[si]  <= 1'b1;
                    due_reg[si]    <= q_req.time_value;
                    param_reg[si]  <= q_req.event_param;
                    reload_reg[si] <= q_req.reload_value;
                end
                CMD_SET_DELTA: if (q_req.slot_ok) begin
                    armed_reg[si] <= 1'b1;
                    due_reg[si]   <= cur_time_reg + q_req.time_value;
                    param_reg[si] <= q_req.event_param;
                end
                CMD_SET_NOW: if (q_req.slot_ok) begin
                    armed_reg[si] <= 1'b1;
                    due_reg[si]   <= cur_time_reg;
                    param_reg[si] <= q_req.event_param;
                end
                CMD_DELETE: if (q_req.slot_ok) begin
                    reg_mark_reg[si] <= 1'b0;
                    armed_reg[si]    <= 1'b0;
                    due_reg[si]      <= '0;
                    reload_reg[si]   <= '0;
                    param_reg[si]    <= '0;
                end
                CMD_CHECK: cur_time_reg <= q_req.now_time;
                default: ;
            endcase
        end else if (state_reg == ST_SCAN && fire && out_free) begin
            if (reload_reg[sc] != '0) begin
                due_reg[sc] <= due_reg[sc] + reload_reg[sc];
            end else begin
                armed_reg[sc] <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/timed_event_scheduler_unit.sv]
// Top level of the timed event scheduler: request queue front end and slot pool back end.
//
//  Channel | Direction | tdata (low to high)                                   | tuser | tlast
//  s_      | in        | mode, slot_index, time_value, reload_value,           | none  | none
//          |           | event_param, now_time (136 bits)                      |       |
//  m_      | out       | kind, out_index, out_time, out_param (72 bits)        | none  | last
//
// A non-check request passes from the queue into the output register when the slot engine
// takes it. A check walks the pool one slot per cycle, pausing on a fired slot while the
// result side stalls; no new request is taken until that scan through the slot array ends.
// A two-entry queue sits between the input side and the slot engine, so up to two
// requests are taken while the engine is busy or the output waits.
// Reset is synchronous and active low; it clears every slot and the current time.
// A stall on m_tready holds the output register and pauses the scan on a fired slot.
`default_nettype none
module timed_event_scheduler_unit
    import tes_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode[3:0], slot_index[7:4], time_value[39:8], reload_value[71:40],
    // event_param[103:72], now_time[135:104]
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // kind[2:0], out_index[6:3], out_time[38:7], out_param[70:39], zero fill above
    output logic [71:0]       m_tdata,
    output logic              m_tlast
);
    logic q_valid, q_ready;
    req_t q_req;
    logic [2:0]  kind;
    logic [3:0]  idx;
    logic [31:0] otime, oparam;

    tes_front #(.POOL_DEPTH(POOL_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_mode(s_tdata[3:0]), .in_slot(s_tdata[7:4]),
        .in_time(s_tdata[39:8]), .in_reload(s_tdata[71:40]),
        .in_param(s_tdata[103:72]), .in_now(s_tdata[135:104]),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    tes_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(kind), .out_index(idx), .out_time(otime), .out_param(oparam),
        .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, oparam, otime, idx, kind};
endmodule
`default_nettype wire

[rtl/tes_checker.sv]
// Port-level checker for the timed event scheduler and its bind to the top level.
`default_nettype none
module tes_checker
    import tes_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata,
    input wire logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == KIND_FIRED |-> !m_tlast)
        else $error("fired result marked last");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == KIND_SCAN_END |-> m_tlast)
        else $error("scan end not marked last");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind timed_event_scheduler_unit tes_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
